### hdl/uyvy_to_i420_converter_defines.svh
// Assertion macros shared by the converter modules.
`ifndef UYVY_TO_I420_CONVERTER_DEFINES_SVH
`define UYVY_TO_I420_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define U2I_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Checked on every rising edge, reset included.
`define U2I_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);
`else
`define U2I_ASSERT(lbl, clk, rst_n, prop, msg)
`define U2I_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/u2i_pkg.sv
`default_nettype none

package u2i_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam int DIM_W = 15;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET = 11'd640;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	typedef enum logic [2:0] {
		CMD_Y,
		CMD_WR_U,
		CMD_WR_V,
		CMD_RD_U,
		CMD_RD_V
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
		logic last;
	} cmd_t;

endpackage

`default_nettype wire

### hdl/u2i_in_if.sv
`default_nettype none

interface u2i_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] data_byte;

	modport source(output valid, output action, output data_byte, input ready);
	modport sink(input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

### hdl/u2i_out_if.sv
`default_nettype none

interface u2i_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [1:0] plane;
	logic last_of_frame;

	modport source(output valid, output out_byte, output plane, output last_of_frame,
		input ready);
	modport sink(input valid, input out_byte, input plane, input last_of_frame,
		output ready);
endinterface

`default_nettype wire

### hdl/u2i_ram.sv
`default_nettype none

module u2i_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = 10
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/u2i_fifo.sv
`default_nettype none

module u2i_fifo import u2i_pkg::*; #(
	parameter int W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [W-1:0] wdata,
	input wire logic pop,
	output logic [W-1:0] rdata,
	output logic full,
	output logic empty
);

	logic [W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/u2i_front.sv
`default_nettype none
`include "uyvy_to_i420_converter_defines.svh"

module u2i_front import u2i_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int ADDR_W = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	u2i_in_if.sink pixel_in,
	input wire logic q_full,
	output logic push,
	output cmd_t cmd,
	output logic [ADDR_W-1:0] addr
);

	localparam int STORE_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int CW = $clog2(2 * MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_WIDTH / 2 + 1);
	localparam int HH = $clog2(MAX_HEIGHT / 2 + 1);
	localparam int EW = $clog2(STORE_DEPTH + 1);
	localparam int DW = $clog2(2 * STORE_DEPTH);
	localparam int PW = RW + HW + 1;

	logic [CFG_DATA_W-1:0] frame_width_q;
	logic [CFG_DATA_W-1:0] frame_height_q;
	logic settle_q;

	logic [DIM_W-1:0] w_raw, h_raw, w_clip, h_clip, w_eff, h_eff;
	logic [HW-1:0] half_w_d, half_w_q;
	logic [HH-1:0] half_h_d;
	logic [CW-1:0] col_end_d, col_end_q;
	logic [RW-1:0] row_end_d, row_end_q;
	logic [HW+HH-1:0] entries_full;
	logic [HW+HH:0] entries_twice_m1;
	logic [EW-1:0] entries_q;
	logic [DW-1:0] drain_end_q;

	logic [CW-1:0] byte_column_q;
	logic [RW-1:0] row_index_q;
	logic draining_q;
	logic [DW-1:0] drain_index_q;

	logic accept;
	logic is_data;
	logic col_wrap, row_wrap;
	logic [PW-1:0] wr_prod;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [DW-1:0] rd_off;
	logic d_is_u, d_last;

	always_comb begin
		w_raw = DIM_W'(frame_width_q);
		h_raw = DIM_W'(frame_height_q);
		if (w_raw < DIM_W'(2)) begin
			w_clip = DIM_W'(2);
		end else if (w_raw > DIM_W'(MAX_WIDTH)) begin
			w_clip = DIM_W'(MAX_WIDTH);
		end else begin
			w_clip = w_raw;
		end
		if (h_raw < DIM_W'(2)) begin
			h_clip = DIM_W'(2);
		end else if (h_raw > DIM_W'(MAX_HEIGHT)) begin
			h_clip = DIM_W'(MAX_HEIGHT);
		end else begin
			h_clip = h_raw;
		end
		w_eff = {w_clip[DIM_W-1:1], 1'b0};
		h_eff = {h_clip[DIM_W-1:1], 1'b0};
		half_w_d = HW'(w_eff >> 1);
		half_h_d = HH'(h_eff >> 1);
		col_end_d = CW'((w_eff << 1) - DIM_W'(1));
		row_end_d = RW'(h_eff - DIM_W'(1));
	end

	assign entries_full = (HW+HH)'(half_w_d) * (HW+HH)'(half_h_d);
	assign entries_twice_m1 = {entries_full, 1'b0} - (HW+HH+1)'(1);

	always_ff @(posedge clk) begin
		half_w_q <= half_w_d;
		col_end_q <= col_end_d;
		row_end_q <= row_end_d;
		entries_q <= EW'(entries_full);
		drain_end_q <= DW'(entries_twice_m1);
	end

	assign pixel_in.ready = !q_full && !settle_q;
	assign accept = pixel_in.valid && pixel_in.ready;
	assign is_data = pixel_in.action == ACT_DATA;

	assign col_wrap = byte_column_q >= col_end_q;
	assign row_wrap = row_index_q >= row_end_q;
	assign wr_prod = PW'(row_index_q >> 1) * PW'(half_w_q);
	assign wr_addr = ADDR_W'(wr_prod + PW'(byte_column_q >> 2));
	assign d_is_u = drain_index_q < DW'(entries_q);
	assign rd_off = drain_index_q - DW'(entries_q);
	assign rd_addr = d_is_u ? ADDR_W'(drain_index_q) : ADDR_W'(rd_off);
	assign d_last = drain_index_q >= drain_end_q;

	always_comb begin
		push = 1'b0;
		cmd.kind = CMD_Y;
		cmd.data = pixel_in.data_byte;
		cmd.last = 1'b0;
		addr = wr_addr;
		if (is_data) begin
			if (byte_column_q[0]) begin
				push = accept && !draining_q;
			end else begin
				push = accept && !draining_q && !row_index_q[0];
				cmd.kind = byte_column_q[1] ? CMD_WR_V : CMD_WR_U;
			end
		end else begin
			push = accept && draining_q;
			cmd.kind = d_is_u ? CMD_RD_U : CMD_RD_V;
			cmd.last = !d_is_u && d_last;
			addr = rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
			settle_q <= 1'b1;
			byte_column_q <= '0;
			row_index_q <= '0;
			draining_q <= 1'b0;
			drain_index_q <= '0;
		end else begin
			settle_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
					CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && is_data && !draining_q) begin
				if (col_wrap) begin
					byte_column_q <= '0;
					if (row_wrap) begin
						row_index_q <= '0;
						draining_q <= 1'b1;
						drain_index_q <= '0;
					end else begin
						row_index_q <= row_index_q + 1'b1;
					end
				end else begin
					byte_column_q <= byte_column_q + 1'b1;
				end
			end else if (accept && !is_data && draining_q) begin
				if (d_last) begin
					draining_q <= 1'b0;
					drain_index_q <= '0;
				end else begin
					drain_index_q <= drain_index_q + 1'b1;
				end
			end
		end
	end

	`U2I_ASSERT_ALWAYS(a_push_room, clk, push |-> !q_full, "Push into a full queue.")
	`U2I_ASSERT(a_cfg_settle, clk, arst_n, cfg_we |=> !pixel_in.ready,
		"Item taken right after a register write.")
	`U2I_ASSERT(a_drain_end, clk, arst_n, (push && cmd.last) |=> !draining_q,
		"Drain did not end after its final byte.")

endmodule

`default_nettype wire

### hdl/u2i_back.sv
`default_nettype none
`include "uyvy_to_i420_converter_defines.svh"

module u2i_back import u2i_pkg::*; #(
	parameter int STORE_DEPTH = 262144,
	parameter int ADDR_W = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire cmd_t q_cmd,
	input wire logic [ADDR_W-1:0] q_addr,
	output logic q_pop,
	u2i_out_if.source plane_out
);

	logic is_wr;
	logic s1_adv, s1_free;
	logic valid_s1;
	cmd_kind_t kind_s1;
	logic [7:0] data_s1;
	logic last_s1;
	logic [7:0] u_rdata, v_rdata;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_plane_q;
	logic out_last_q;

	assign is_wr = q_cmd.kind inside {CMD_WR_U, CMD_WR_V};
	assign s1_adv = valid_s1 && (!out_valid_q || plane_out.ready);
	assign s1_free = !valid_s1 || s1_adv;
	assign q_pop = !q_empty && (is_wr || s1_free);

	u2i_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH), .ADDR_W(ADDR_W)) store_u (
		.clk(clk),
		.we(q_pop && q_cmd.kind == CMD_WR_U),
		.waddr(q_addr),
		.wdata(q_cmd.data),
		.re(q_pop && q_cmd.kind == CMD_RD_U),
		.raddr(q_addr),
		.rdata(u_rdata)
	);

	u2i_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH), .ADDR_W(ADDR_W)) store_v (
		.clk(clk),
		.we(q_pop && q_cmd.kind == CMD_WR_V),
		.waddr(q_addr),
		.wdata(q_cmd.data),
		.re(q_pop && q_cmd.kind == CMD_RD_V),
		.raddr(q_addr),
		.rdata(v_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop && !is_wr) begin
			kind_s1 <= q_cmd.kind;
			data_s1 <= q_cmd.data;
			last_s1 <= q_cmd.last;
		end
		if (s1_adv) begin
			case (kind_s1)
				CMD_RD_U: begin
					out_byte_q <= u_rdata;
					out_plane_q <= PLANE_U;
					out_last_q <= 1'b0;
				end
				CMD_RD_V: begin
					out_byte_q <= v_rdata;
					out_plane_q <= PLANE_V;
					out_last_q <= last_s1;
				end
				default: begin
					out_byte_q <= data_s1;
					out_plane_q <= PLANE_Y;
					out_last_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && !is_wr) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (plane_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign plane_out.valid = out_valid_q;
	assign plane_out.out_byte = out_byte_q;
	assign plane_out.plane = out_plane_q;
	assign plane_out.last_of_frame = out_last_q;

	`U2I_ASSERT_ALWAYS(a_pop_nonempty, clk, q_pop |-> !q_empty, "Pop from an empty queue.")
	`U2I_ASSERT(a_result_staged, clk, arst_n, (q_pop && !is_wr) |=> valid_s1,
		"Popped result was not staged.")
	`U2I_ASSERT(a_last_is_v, clk, arst_n,
		(plane_out.valid && plane_out.last_of_frame) |-> plane_out.plane == PLANE_V,
		"Frame end marked on a byte outside the V plane.")

endmodule

`default_nettype wire

### hdl/uyvy_to_i420_converter.sv
`default_nettype none

// Converts a packed UYVY 4:2:2 frame, one byte per transfer, into planar I420. Luma bytes come
// out as Y results via the queue, a staging register and the output register; chroma bytes
// of even rows go into two byte-wide RAMs of (MAX_WIDTH/2)*(MAX_HEIGHT/2) entries each, and
// those of odd rows are dropped. After the last byte of a frame, each drain transfer reads
// one stored byte, all U then all V, by the same path; the final V byte carries last_of_frame.
// The block takes one transfer per clock while the output keeps up; a two-entry command queue
// decouples input from output, and the store has one read and one write port per plane.
// Write frame_width and frame_height only while the block is idle; input ready drops for one
// cycle after each register write while the derived frame geometry is recomputed.
module uyvy_to_i420_converter import u2i_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	u2i_in_if.sink pixel_in,
	u2i_out_if.source plane_out
);

	localparam int STORE_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int QW = $bits(cmd_t) + ADDR_W;

	logic push;
	cmd_t push_cmd;
	logic [ADDR_W-1:0] push_addr;
	logic q_full, q_empty, q_pop;
	logic [QW-1:0] q_rdata;
	cmd_t q_cmd;
	logic [ADDR_W-1:0] q_addr;

	u2i_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .ADDR_W(ADDR_W)) front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_in(pixel_in),
		.q_full(q_full),
		.push(push),
		.cmd(push_cmd),
		.addr(push_addr)
	);

	u2i_fifo #(.W(QW)) queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({push_addr, push_cmd}),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	assign q_addr = q_rdata[QW-1:$bits(cmd_t)];
	assign q_cmd = q_rdata[$bits(cmd_t)-1:0];

	u2i_back #(.STORE_DEPTH(STORE_DEPTH), .ADDR_W(ADDR_W)) back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(q_cmd),
		.q_addr(q_addr),
		.q_pop(q_pop),
		.plane_out(plane_out)
	);

endmodule

`default_nettype wire

### tb/uyvy_to_i420_converter_test.sv
`timescale 1ns / 1ps

module uyvy_to_i420_converter_test;
	import u2i_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int STORE_ENTRIES = (MAX_W / 2) * (MAX_H / 2);
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEM_TARGET = 1300;
	localparam int TAIL_BYTES = 100;

	typedef struct {
		logic act;
		logic [7:0] value;
	} stream_item_t;

	typedef struct {
		logic [7:0] value;
		logic [1:0] plane;
		logic last;
	} plane_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	u2i_in_if pixel_bus();
	u2i_out_if plane_bus();

	uyvy_to_i420_converter #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_in(pixel_bus),
		.plane_out(plane_bus)
	);

	bit [15:0] chroma_copy [STORE_ENTRIES];
	int width_reg = FRAME_WIDTH_RESET;
	int height_reg = FRAME_HEIGHT_RESET;
	int byte_col;
	int row_num;
	int drain_pos;
	bit draining;

	stream_item_t uyvy_stream[$];
	plane_byte_t plane_bytes_due[$];
	stream_item_t next_item;
	plane_byte_t predicted_byte;
	plane_byte_t due_byte;

	int items_queued;
	int items_accepted;
	int results_checked;
	int mismatches;
	int frames_run;
	int geometries_run;
	int send_gap;
	int ready_hold;
	int idle_cycles;
	bit calm_in;
	bit calm_out;
	bit pressure_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int usable_dim(input int reg_value, input int cap);
		int v;
		v = reg_value;
		if (v < 2) v = 2;
		if (v > cap) v = cap;
		return v & ~1;
	endfunction

	function automatic bit convert_byte(input logic act, input logic [7:0] value,
			output plane_byte_t res);
		int w;
		int h;
		int half_w;
		int entries;
		int slot;
		bit [15:0] pair;
		bit last;
		bit emitted;
		w = usable_dim(width_reg, MAX_W);
		h = usable_dim(height_reg, MAX_H);
		half_w = w / 2;
		entries = half_w * (h / 2);
		emitted = 1'b0;
		res = '{8'h00, PLANE_Y, 1'b0};
		if (act == ACT_DATA) begin
			if (draining) return 1'b0;
			if ((byte_col & 1) != 0) begin
				res = '{value, PLANE_Y, 1'b0};
				emitted = 1'b1;
			end else if ((row_num & 1) == 0) begin
				slot = (row_num / 2) * half_w + byte_col / 4;
				if ((byte_col & 2) == 0) chroma_copy[slot][7:0] = value;
				else chroma_copy[slot][15:8] = value;
			end
			if (byte_col >= 2 * w - 1) begin
				byte_col = 0;
				if (row_num >= h - 1) begin
					row_num = 0;
					draining = 1'b1;
					drain_pos = 0;
				end else begin
					row_num++;
				end
			end else begin
				byte_col++;
			end
			return emitted;
		end
		if (!draining) return 1'b0;
		slot = (drain_pos < entries) ? drain_pos : drain_pos - entries;
		pair = chroma_copy[slot];
		last = drain_pos >= 2 * entries - 1;
		if (drain_pos < entries) res = '{pair[7:0], PLANE_U, 1'b0};
		else res = '{pair[15:8], PLANE_V, last};
		if (last) begin
			draining = 1'b0;
			drain_pos = 0;
		end else begin
			drain_pos++;
		end
		return 1'b1;
	endfunction

	function automatic int idle_gap(input bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_item(input logic act, input logic [7:0] value);
		uyvy_stream.push_back('{act, value});
		items_queued++;
	endfunction

	// Stray items are drain steps inside a frame and data bytes inside a drain; both are ignored.
	function automatic int queue_frame(input bit noisy);
		int w;
		int h;
		int count;
		w = usable_dim(width_reg, MAX_W);
		h = usable_dim(height_reg, MAX_H);
		count = 0;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < 2 * w; c++) begin
				if (noisy && $urandom_range(0, 29) == 0)
					push_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
				push_item(ACT_DATA, 8'($urandom_range(0, 255)));
				count++;
			end
		end
		for (int d = 0; d < w * h / 2; d++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				push_item(ACT_DATA, 8'($urandom_range(0, 255)));
			push_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
			count++;
		end
		frames_run++;
		return count;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAME_WIDTH) width_reg = value & 'h7FF;
		else height_reg = value & 'h7FF;
	endtask

	task automatic settle();
		while (items_accepted != items_queued || plane_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && (!pixel_bus.valid || pixel_bus.ready)) begin
			if (send_gap > 0) begin
				send_gap--;
				pixel_bus.valid <= 1'b0;
			end else if (uyvy_stream.size() != 0) begin
				next_item = uyvy_stream.pop_front();
				pixel_bus.action <= next_item.act;
				pixel_bus.data_byte <= next_item.value;
				pixel_bus.valid <= 1'b1;
				send_gap = idle_gap(calm_in);
			end else begin
				pixel_bus.valid <= 1'b0;
			end
		end
	end

	// The long hold-off lets the sender keep offering until the block backs up to its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!pressure_done && uyvy_stream.size() > 40) begin
				pressure_done = 1'b1;
				ready_hold = HOLD_OFF_CYCLES;
			end
			if (ready_hold > 0) begin
				ready_hold--;
				plane_bus.ready <= 1'b0;
			end else begin
				plane_bus.ready <= 1'b1;
				ready_hold = idle_gap(calm_out);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_bus.valid && pixel_bus.ready) begin
			items_accepted++;
			if (convert_byte(pixel_bus.action, pixel_bus.data_byte, predicted_byte))
				plane_bytes_due.push_back(predicted_byte);
		end
	end

	always @(posedge clk) begin
		if (arst_n && plane_bus.valid && plane_bus.ready) begin
			results_checked++;
			if (plane_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: byte %h plane %0d last %b",
						plane_bus.out_byte, plane_bus.plane, plane_bus.last_of_frame);
			end else begin
				due_byte = plane_bytes_due.pop_front();
				if (due_byte.value !== plane_bus.out_byte || due_byte.plane !== plane_bus.plane
						|| due_byte.last !== plane_bus.last_of_frame) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch at result %0d: expected byte %h plane %0d last %b,",
							" got byte %h plane %0d last %b"}, results_checked,
							due_byte.value, due_byte.plane, due_byte.last,
							plane_bus.out_byte, plane_bus.plane, plane_bus.last_of_frame);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_bus.valid && pixel_bus.ready) || (plane_bus.valid && plane_bus.ready)
					|| cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, plane_bytes_due.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int w_reg;
		int h_reg;
		int roll;
		int frames;
		pixel_bus.valid = 1'b0;
		pixel_bus.action = ACT_DATA;
		pixel_bus.data_byte = 8'h00;
		plane_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Register values below the minimum and odd both end up as a 2x2 frame.
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 3);
		geometries_run++;
		push_item(ACT_DRAIN, 8'h00);
		push_item(ACT_DATA, 8'h00);
		push_item(ACT_DATA, 8'hFF);
		push_item(ACT_DATA, 8'h80);
		push_item(ACT_DATA, 8'h01);
		push_item(ACT_DATA, 8'h7F);
		push_item(ACT_DATA, 8'hFE);
		push_item(ACT_DATA, 8'h55);
		push_item(ACT_DATA, 8'hAA);
		push_item(ACT_DATA, 8'h33);
		push_item(ACT_DRAIN, 8'hFF);
		push_item(ACT_DRAIN, 8'h00);
		frames_run++;
		settle();

		while (items_queued < ITEM_TARGET - TAIL_BYTES) begin
			roll = $urandom_range(0, 9);
			if (roll == 0) w_reg = $urandom_range(0, 3);
			else if (roll == 1) w_reg = $urandom_range(9, 17);
			else w_reg = 2 * $urandom_range(1, 8);
			roll = $urandom_range(0, 9);
			if (roll == 0) h_reg = $urandom_range(0, 3);
			else if (roll == 1) h_reg = $urandom_range(5, 9);
			else h_reg = 2 * $urandom_range(1, 4);
			write_reg(CFG_FRAME_WIDTH, w_reg);
			write_reg(CFG_FRAME_HEIGHT, h_reg);
			geometries_run++;
			calm_in = ($urandom_range(0, 3) == 0);
			calm_out = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++)
				if (items_queued < ITEM_TARGET - TAIL_BYTES)
					void'(queue_frame(1'b1));
			settle();
		end

		// Registers above the maximum clamp to the largest frame; TAIL_BYTES of its first row are sent.
		write_reg(CFG_FRAME_WIDTH, 2047);
		write_reg(CFG_FRAME_HEIGHT, 2047);
		geometries_run++;
		calm_in = 1'b0;
		calm_out = 1'b0;
		for (int b = 0; b < TAIL_BYTES; b++)
			push_item(ACT_DATA, 8'($urandom_range(0, 255)));
		settle();

		$display("Covered %0d frames in %0d geometries with clamped and odd registers,",
			frames_run, geometries_run);
		$display("stray items and a partial largest frame; %0d items in, %0d bytes out checked.",
			items_accepted, results_checked);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatching results", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/u2i_pkg.sv
hdl/u2i_in_if.sv
hdl/u2i_out_if.sv
hdl/u2i_ram.sv
hdl/u2i_fifo.sv
hdl/u2i_front.sv
hdl/u2i_back.sv
hdl/uyvy_to_i420_converter.sv
tb/uyvy_to_i420_converter_test.sv
